### sv/iso_ep_pkg.sv
// ----------------------------------------------------------------------------
// iso_ep_pkg
// Shared types, character codes, status codes and calendar helpers for the
// ISO 8601 UTC timestamp to Unix seconds converter.
// ----------------------------------------------------------------------------
package iso_ep_pkg;

   // Result status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FORMAT   = 3'd1;
   localparam logic [2:0] ST_FRACTION = 3'd2;
   localparam logic [2:0] ST_TIMEZONE = 3'd3;
   localparam logic [2:0] ST_DIGIT    = 3'd4;
   localparam logic [2:0] ST_RANGE    = 3'd5;

   // Bit positions in the sticky error flag vector.
   localparam int FLAG_FORMAT   = 0;
   localparam int FLAG_FRACTION = 1;
   localparam int FLAG_TIMEZONE = 2;
   localparam int FLAG_DIGIT    = 3;

   // ASCII codes that the parser looks for.
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Z     = 8'h5A;

   // Fields captured when the final character of a timestamp is taken.
   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [2:0]  status;
   } fields_type;

   // Days in a month of a common year; month is 1..12.
   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd2: begin
            len = 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

   // Days before the first of the month in a year that starts on March 1.
   function automatic logic [8:0] month_offset(input logic [3:0] month);
      logic [8:0] ofs;
      case (month)
         4'd3: begin
            ofs = 9'd0;
         end
         4'd4: begin
            ofs = 9'd31;
         end
         4'd5: begin
            ofs = 9'd61;
         end
         4'd6: begin
            ofs = 9'd92;
         end
         4'd7: begin
            ofs = 9'd122;
         end
         4'd8: begin
            ofs = 9'd153;
         end
         4'd9: begin
            ofs = 9'd184;
         end
         4'd10: begin
            ofs = 9'd214;
         end
         4'd11: begin
            ofs = 9'd245;
         end
         4'd12: begin
            ofs = 9'd275;
         end
         4'd1: begin
            ofs = 9'd306;
         end
         4'd2: begin
            ofs = 9'd337;
         end
         default: begin
            ofs = 9'd0;
         end
      endcase
      return ofs;
   endfunction

endpackage

### sv/iso_ep_if.sv
// ----------------------------------------------------------------------------
// iso_ep_if
// Valid/ready channels for the timestamp characters and the converted results.
// ----------------------------------------------------------------------------
interface iso_ep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface iso_ep_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [38:0] unix_time;

   modport source (output valid, output status, output unix_time, input ready);
   modport sink   (input valid, input status, input unix_time, output ready);
endinterface

### sv/iso_ep_parse.sv
// ----------------------------------------------------------------------------
// iso_ep_parse
// Character parser: checks separators, digits, fraction and suffix, and
// accumulates the decimal date and time fields one character at a time.
// ----------------------------------------------------------------------------
module iso_ep_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             char_code,
   input  logic                   is_last,
   output logic                   done,
   output iso_ep_pkg::fields_type fields
);

   logic [5:0]  pos_ff,    pos_in;
   logic [13:0] year_ff,   year_in;
   logic [6:0]  month_ff,  month_in;
   logic [6:0]  day_ff,    day_in;
   logic [6:0]  hour_ff,   hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [3:0]  flags_ff,  flags_in;
   logic        frac_ff,   frac_in;

   logic        dig;
   logic [3:0]  dv;
   logic [2:0]  status;

   always_comb begin
      dig       = (char_code >= iso_ep_pkg::CH_ZERO) && (char_code <= iso_ep_pkg::CH_NINE);
      dv        = char_code[3:0];
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      flags_in  = flags_ff;
      frac_in   = frac_ff;

      if (pos_ff < 6'd19) begin
         if (pos_ff == 6'd4 || pos_ff == 6'd7) begin
            if (char_code != iso_ep_pkg::CH_DASH) begin
               flags_in[iso_ep_pkg::FLAG_FORMAT] = 1'b1;
            end
         end else if (pos_ff == 6'd10) begin
            if (char_code != iso_ep_pkg::CH_T) begin
               flags_in[iso_ep_pkg::FLAG_FORMAT] = 1'b1;
            end
         end else if (pos_ff == 6'd13 || pos_ff == 6'd16) begin
            if (char_code != iso_ep_pkg::CH_COLON) begin
               flags_in[iso_ep_pkg::FLAG_FORMAT] = 1'b1;
            end
         end else if (!dig) begin
            flags_in[iso_ep_pkg::FLAG_DIGIT] = 1'b1;
         end else if (pos_ff < 6'd4) begin
            year_in = 14'({year_ff, 3'b000}) + 14'({year_ff, 1'b0}) + 14'(dv);
         end else if (pos_ff < 6'd7) begin
            month_in = 7'({month_ff, 3'b000}) + 7'({month_ff, 1'b0}) + 7'(dv);
         end else if (pos_ff < 6'd10) begin
            day_in = 7'({day_ff, 3'b000}) + 7'({day_ff, 1'b0}) + 7'(dv);
         end else if (pos_ff < 6'd13) begin
            hour_in = 7'({hour_ff, 3'b000}) + 7'({hour_ff, 1'b0}) + 7'(dv);
         end else if (pos_ff < 6'd16) begin
            minute_in = 7'({minute_ff, 3'b000}) + 7'({minute_ff, 1'b0}) + 7'(dv);
         end else begin
            second_in = 7'({second_ff, 3'b000}) + 7'({second_ff, 1'b0}) + 7'(dv);
         end
      end else if (pos_ff == 6'd19) begin
         if (char_code == iso_ep_pkg::CH_DOT) begin
            frac_in = 1'b1;
         end else if (char_code != iso_ep_pkg::CH_Z) begin
            flags_in[iso_ep_pkg::FLAG_TIMEZONE] = 1'b1;
         end
      end else if (frac_ff) begin
         if (!is_last && !dig) begin
            flags_in[iso_ep_pkg::FLAG_FRACTION] = 1'b1;
         end
      end else begin
         flags_in[iso_ep_pkg::FLAG_TIMEZONE] = 1'b1;
      end

      pos_in = (pos_ff == 6'd63) ? pos_ff : pos_ff + 6'd1;

      // Errors that the character stream alone decides, in rank order.
      if (pos_ff < 6'd19 || flags_in[iso_ep_pkg::FLAG_FORMAT]) begin
         status = iso_ep_pkg::ST_FORMAT;
      end else if (frac_in && (char_code != iso_ep_pkg::CH_Z || pos_ff == 6'd20 ||
                               flags_in[iso_ep_pkg::FLAG_FRACTION])) begin
         status = iso_ep_pkg::ST_FRACTION;
      end else if (!frac_in && flags_in[iso_ep_pkg::FLAG_TIMEZONE]) begin
         status = iso_ep_pkg::ST_TIMEZONE;
      end else if (flags_in[iso_ep_pkg::FLAG_DIGIT]) begin
         status = iso_ep_pkg::ST_DIGIT;
      end else begin
         status = iso_ep_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && is_last)) begin
         pos_ff    <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         flags_ff  <= '0;
         frac_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         flags_ff  <= flags_in;
         frac_ff   <= frac_in;
      end
   end

   assign done          = accept && is_last;
   assign fields.year   = year_in;
   assign fields.month  = month_in;
   assign fields.day    = day_in;
   assign fields.hour   = hour_in;
   assign fields.minute = minute_in;
   assign fields.second = second_in;
   assign fields.status = status;

endmodule

### sv/iso_ep_calc.sv
// ----------------------------------------------------------------------------
// iso_ep_calc
// Range checks and days-from-civil arithmetic, five register stages that all
// advance together; the last stage is the result register.
// ----------------------------------------------------------------------------
module iso_ep_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   load,
   input  iso_ep_pkg::fields_type fields,
   output logic                   result_valid,
   output logic [2:0]             result_status,
   output logic signed [38:0]     result_seconds
);

   // Reciprocals for exact division of values below 2^15 by 400 and by 25.
   localparam logic [15:0] RECIP_400 = 16'd41944;
   localparam int          SHIFT_400 = 24;
   localparam logic [15:0] RECIP_25  = 16'd41944;
   localparam int          SHIFT_25  = 20;

   // Stage 1: captured fields.
   logic                   v1_ff;
   iso_ep_pkg::fields_type f1_ff;

   // Stage 2: quotients and partial sums.
   logic        v2_ff;
   logic [2:0]  st2_ff;
   logic [14:0] yp2_ff;
   logic [5:0]  q400_2_ff;
   logic [9:0]  q25_2_ff;
   logic [13:0] y2_ff;
   logic [6:0]  m2_ff;
   logic [6:0]  d2_ff;
   logic        hms_bad2_ff;
   logic [8:0]  doy2_ff;
   logic [16:0] hms2_ff;

   // Stage 3: final status, day of era and the shifted era quotient.
   logic        v3_ff;
   logic [2:0]  st3_ff;
   logic [17:0] doe3_ff;
   logic [5:0]  q400_3_ff;
   logic [16:0] hms3_ff;

   // Stage 4: days since the epoch.
   logic               v4_ff;
   logic [2:0]         st4_ff;
   logic signed [24:0] days4_ff;
   logic [16:0]        hms4_ff;

   // Stage 5: result register.
   logic               v5_ff;
   logic [2:0]         st5_ff;
   logic signed [38:0] secs5_ff;

   // Stage 2 logic.
   logic [14:0] yp_in;
   logic [30:0] prod400;
   logic [29:0] prod25;
   logic [3:0]  mp_month;
   logic [8:0]  doy_in;
   logic [16:0] hms_in;
   logic        hms_bad_in;

   always_comb begin
      yp_in      = 15'(f1_ff.year) + 15'd400 - ((f1_ff.month <= 7'd2) ? 15'd1 : 15'd0);
      prod400    = 31'(yp_in) * 31'(RECIP_400);
      prod25     = 30'(f1_ff.year) * 30'(RECIP_25);
      mp_month   = f1_ff.month[3:0];
      doy_in     = iso_ep_pkg::month_offset(mp_month) + 9'(f1_ff.day) - 9'd1;
      hms_in     = 17'(17'(f1_ff.hour) * 17'd3600) + 17'(17'(f1_ff.minute) * 17'd60) +
                   17'(f1_ff.second);
      hms_bad_in = (f1_ff.hour > 7'd23) || (f1_ff.minute > 7'd59) || (f1_ff.second > 7'd59);
   end

   // Stage 3 logic.
   logic [14:0] yoe_full;
   logic [8:0]  yoe;
   logic [1:0]  yoe_cent;
   logic [17:0] doe_in;
   logic        div25;
   logic        leap;
   logic [5:0]  mdays;
   logic [2:0]  st3_in;

   always_comb begin
      yoe_full = yp2_ff - 15'(15'(q400_2_ff) * 15'd400);
      yoe      = yoe_full[8:0];
      yoe_cent = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
      doe_in   = 18'(18'(yoe) * 18'd365) + 18'(yoe[8:2]) - 18'(yoe_cent) + 18'(doy2_ff);
      div25    = (14'(14'(q25_2_ff) * 14'd25) == y2_ff);
      // Divisible by 4, and either not by 100 or also by 400 (by 16 and by 25).
      leap     = (y2_ff[1:0] == 2'b00) && (!div25 || (y2_ff[3:0] == 4'b0000));
      mdays    = 6'(iso_ep_pkg::month_length(m2_ff[3:0])) +
                 (((m2_ff == 7'd2) && leap) ? 6'd1 : 6'd0);
      if (st2_ff != iso_ep_pkg::ST_OK) begin
         st3_in = st2_ff;
      end else if (m2_ff == 7'd0 || m2_ff > 7'd12 || d2_ff == 7'd0) begin
         st3_in = iso_ep_pkg::ST_RANGE;
      end else if (d2_ff > 7'(mdays) || hms_bad2_ff) begin
         st3_in = iso_ep_pkg::ST_RANGE;
      end else begin
         st3_in = iso_ep_pkg::ST_OK;
      end
   end

   // Stage 4 logic: the year was shifted up by one era, so era is quotient minus one.
   logic signed [6:0]  era;
   logic signed [24:0] days_in;

   always_comb begin
      era     = $signed({1'b0, q400_3_ff}) - 7'sd1;
      days_in = 25'(era) * 25'sd146097 + $signed({7'b0, doe3_ff}) - 25'sd719468;
   end

   // Stage 5 logic.
   logic signed [42:0] secs_in;

   always_comb begin
      secs_in = 43'(days4_ff) * 43'sd86400 + $signed({26'b0, hms4_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= load;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff       <= fields;

         st2_ff      <= f1_ff.status;
         yp2_ff      <= yp_in;
         q400_2_ff   <= prod400[SHIFT_400 +: 6];
         q25_2_ff    <= prod25[SHIFT_25 +: 10];
         y2_ff       <= f1_ff.year;
         m2_ff       <= f1_ff.month;
         d2_ff       <= f1_ff.day;
         hms_bad2_ff <= hms_bad_in;
         doy2_ff     <= doy_in;
         hms2_ff     <= hms_in;

         st3_ff      <= st3_in;
         doe3_ff     <= doe_in;
         q400_3_ff   <= q400_2_ff;
         hms3_ff     <= hms2_ff;

         st4_ff      <= st3_ff;
         days4_ff    <= days_in;
         hms4_ff     <= hms3_ff;

         st5_ff      <= st4_ff;
         secs5_ff    <= (st4_ff == iso_ep_pkg::ST_OK) ? secs_in[38:0] : 39'sd0;
      end
   end

   assign result_valid   = v5_ff;
   assign result_status  = st5_ff;
   assign result_seconds = secs5_ff;

endmodule

### sv/iso8601_utc_timestamp_to_epoch.sv
// ----------------------------------------------------------------------------
// iso8601_utc_timestamp_to_epoch
// Converts an ISO 8601 UTC timestamp, one character per transaction, into
// Unix seconds or an error status.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result side takes results.
// The first of the five calendar stages captures the fields at the edge that
// accepts the final character; rsp valid rises when the result reaches the last stage.
// The whole pipeline stalls only while an unaccepted result is held.
// Reset clears the parser state and all pipeline valid bits.
module iso8601_utc_timestamp_to_epoch (
   input  logic         clock,
   input  logic         reset,
   iso_ep_req_if.sink   req_ch,
   iso_ep_rsp_if.source rsp_ch
);

   logic                   advance;
   logic                   accept;
   logic                   done;
   iso_ep_pkg::fields_type fields;

   // Every stage moves when the result register is empty or being drained.
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   iso_ep_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_ch.char_code),
      .is_last   (req_ch.is_last),
      .done      (done),
      .fields    (fields)
   );

   iso_ep_calc u_calc (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .load           (done),
      .fields         (fields),
      .result_valid   (rsp_ch.valid),
      .result_status  (rsp_ch.status),
      .result_seconds (rsp_ch.unix_time)
   );

endmodule
